// ----- src/burng_pkg.sv -----
// Package for the bounded uniform index generator.
// Holds the generator constants and the sequencer state type; no dependencies.
`default_nettype none

package burng_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = WordW / 2;

	localparam logic [WordW-1:0] GoldenGamma = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WordW-1:0] MixMulA     = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WordW-1:0] MixMulB     = 64'h94D0_49BB_1331_11EB;
	localparam int unsigned MixShiftA = 30;
	localparam int unsigned MixShiftB = 27;
	localparam int unsigned MixShiftC = 31;

	localparam logic ReqDraw = 1'b0;
	localparam logic ReqSeed = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_THR_DIV,
		ST_ADV,
		ST_MUL_A,
		ST_MUL_B,
		ST_CHECK,
		ST_MOD_DIV,
		ST_DONE
	} seq_state_t;

endpackage

`default_nettype wire

// ----- src/bounded_uniform_index_rng_top.sv -----
// Bounded uniform index generator: SplitMix64 state with rejection sampling.
// Uses burng_pkg for constants and the sequencer state type.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------
//   in      | in_valid / in_stall    | req_type, limit, seed
//   out     | out_valid / out_stall  | index
//
// A seed word, or a draw with a limit of at most one, goes straight to completion. Any other
// draw runs a 64-bit remainder pass for the rejection threshold, then for each generator
// output an advance, two multiply states and a check, and a second remainder pass on the
// accepted output; the shared radix-2 divider does both passes.
// arst_n clears the sequencer and loads the golden-ratio constant into the state.
// A new word is taken whenever the sequencer is idle; a stalled result stays put.
`default_nettype none

module bounded_uniform_index_rng_top
	import burng_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             req_type,
	input  wire logic [WordW-1:0] limit,
	input  wire logic [WordW-1:0] seed,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [WordW-1:0]      index
);

	localparam int unsigned CntW = $clog2(WordW);
	localparam logic [CntW-1:0] CntLast = CntW'(WordW - 1);

	seq_state_t state_q, state_d;

	logic [WordW-1:0] gen_q;
	logic [WordW-1:0] lim_q;
	logic [WordW-1:0] thr_q;
	logic [WordW-1:0] z_q;
	logic [WordW-1:0] acc_q;
	logic [WordW-1:0] res_q;
	logic [WordW-1:0] rem_q;
	logic [WordW-1:0] dvd_q;
	logic [CntW-1:0]  cnt_q;
	logic [1:0]       mstep_q;
	logic             out_valid_q;
	logic [WordW-1:0] index_q;

	logic             in_acc;
	logic             out_free;
	logic [WordW-1:0] gen_adv;
	logic [HalfW-1:0] mul_a;
	logic [HalfW-1:0] mul_b;
	logic [WordW-1:0] mul_const;
	logic [WordW-1:0] prod;
	logic [WordW-1:0] mul_sum;
	logic [WordW:0]   div_r;
	logic [WordW:0]   div_diff;
	logic [WordW-1:0] rem_next;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign gen_adv  = gen_q + GoldenGamma;

	// Shared multiplier: the low 64 bits of z times a constant, built from three
	// 32x32 partial products on successive cycles.
	always_comb begin
		mul_const = (state_q == ST_MUL_B) ? MixMulB : MixMulA;
		mul_a     = (mstep_q == 2'd2) ? z_q[WordW-1:HalfW] : z_q[HalfW-1:0];
		mul_b     = (mstep_q == 2'd1) ? mul_const[WordW-1:HalfW] : mul_const[HalfW-1:0];
		prod      = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};
		mul_sum   = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
	end

	// Shared restoring divider step: one quotient bit per cycle, remainder only.
	always_comb begin
		div_r    = {rem_q, dvd_q[WordW-1]};
		div_diff = div_r - {1'b0, lim_q};
		rem_next = div_diff[WordW] ? div_r[WordW-1:0] : div_diff[WordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == ReqSeed || limit <= WordW'(1)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_THR_DIV;
					end
				end
			end
			ST_THR_DIV: begin
				if (cnt_q == CntLast) state_d = ST_ADV;
			end
			ST_ADV: state_d = ST_MUL_A;
			ST_MUL_A: begin
				if (mstep_q == 2'd2) state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				if (mstep_q == 2'd2) state_d = ST_CHECK;
			end
			ST_CHECK: state_d = (z_q >= thr_q) ? ST_MOD_DIV : ST_ADV;
			ST_MOD_DIV: begin
				if (cnt_q == CntLast) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Generator state, control counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= GoldenGamma;
			cnt_q       <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && req_type == ReqSeed) begin
				gen_q <= (seed == '0) ? GoldenGamma : seed;
			end else if (state_q == ST_ADV) begin
				gen_q <= gen_adv;
			end

			if (state_q == ST_THR_DIV || state_q == ST_MOD_DIV) begin
				cnt_q <= cnt_q + CntW'(1);
			end else begin
				cnt_q <= '0;
			end

			if (state_q == ST_MUL_A || state_q == ST_MUL_B) begin
				mstep_q <= (mstep_q == 2'd2) ? 2'd0 : mstep_q + 2'd1;
			end else begin
				mstep_q <= '0;
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					lim_q <= limit;
					res_q <= '0;
					rem_q <= '0;
					dvd_q <= ~limit + WordW'(1);
				end
			end
			ST_THR_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[WordW-2:0], 1'b0};
				if (cnt_q == CntLast) thr_q <= rem_next;
			end
			ST_ADV: begin
				z_q <= gen_adv ^ (gen_adv >> MixShiftA);
			end
			ST_MUL_A, ST_MUL_B: begin
				case (mstep_q)
					2'd0: acc_q <= prod;
					2'd1: acc_q <= mul_sum;
					default: begin
						if (state_q == ST_MUL_A) begin
							z_q <= mul_sum ^ (mul_sum >> MixShiftB);
						end else begin
							z_q <= mul_sum ^ (mul_sum >> MixShiftC);
						end
					end
				endcase
			end
			ST_CHECK: begin
				rem_q <= '0;
				dvd_q <= z_q;
			end
			ST_MOD_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[WordW-2:0], 1'b0};
				if (cnt_q == CntLast) res_q <= rem_next;
			end
			ST_DONE: begin
				if (out_free) index_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign index     = index_q;

	// A result handed to the output is below the limit of its draw, or zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (res_q == '0 || res_q < lim_q))
		else $error("result not below limit");

	// The rejection threshold is a remainder by the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) |-> (thr_q < lim_q))
		else $error("threshold not below limit");

	// An accepted output always leads straight to a modulo pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && z_q >= thr_q) |=> (state_q == ST_MOD_DIV && cnt_q == '0))
		else $error("accepted output did not start the modulo pass");

	// The output register is only loaded from the completion state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result word raised outside completion");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bounded_uniform_index_rng_top: a SplitMix64 index predictor,
// random idling on both channels and a long output hold-off. Depends on burng_pkg and the DUT.

module testbench;
	import burng_pkg::*;

	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned DrainCycles = 300;
	localparam int unsigned CycleLimit  = 800000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             req_type = ReqDraw;
	logic [WordW-1:0] limit = '0;
	logic [WordW-1:0] seed = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [WordW-1:0] index;

	// Predictor state and the indices still owed by the block, oldest first.
	logic [WordW-1:0] mix_state = GoldenGamma;
	logic [WordW-1:0] expected_index[$];
	logic [WordW-1:0] index_due;

	int unsigned error_count = 0;
	int unsigned results_checked = 0;
	int unsigned draws_sent = 0;
	int unsigned seeds_sent = 0;
	int unsigned redraws = 0;
	int unsigned cycle_count = 0;
	int unsigned sink_gap = 0;
	int unsigned sink_draw;
	bit          no_idle = 1'b0;
	bit          hold_request = 1'b0;
	logic        hold_off = 1'b0;

	bounded_uniform_index_rng_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.limit     (limit),
		.seed      (seed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.index     (index)
	);

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Timed out after %0d cycles with %0d indices outstanding",
				cycle_count, expected_index.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [WordW-1:0] want,
		input logic [WordW-1:0] got);
		error_count++;
		$display("%0t: %s: expected 0x%016h, got 0x%016h", $realtime, what, want, got);
	endtask

	// One SplitMix64 step of the predictor state.
	function automatic logic [WordW-1:0] mix_step();
		logic [WordW-1:0] z;
		mix_state = mix_state + GoldenGamma;
		z = mix_state;
		z = (z ^ (z >> MixShiftA)) * MixMulA;
		z = (z ^ (z >> MixShiftB)) * MixMulB;
		return z ^ (z >> MixShiftC);
	endfunction

	function automatic logic [WordW-1:0] predict_index(input logic kind,
		input logic [WordW-1:0] bound, input logic [WordW-1:0] new_seed);
		logic [WordW-1:0] wrapped;
		logic [WordW-1:0] threshold;
		logic [WordW-1:0] z;
		if (kind == ReqSeed) begin
			mix_state = (new_seed == '0) ? GoldenGamma : new_seed;
			return '0;
		end
		if (bound <= 1)
			return '0;
		wrapped = '0 - bound;
		threshold = wrapped % bound;
		z = mix_step();
		while (z < threshold) begin
			redraws++;
			z = mix_step();
		end
		return z % bound;
	endfunction

	// Limits spread over the cases that matter: trivial, small, around 2^63 (where, above it, about
	// half the outputs are rejected), powers of two, near the top, and anything at all.
	function automatic logic [WordW-1:0] pick_limit();
		int unsigned kind;
		logic [WordW-1:0] value;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			value = WordW'($urandom_range(0, 3));
		end else if (kind < 35) begin
			value = WordW'($urandom_range(2, 1000));
		end else if (kind < 50) begin
			value = WordW'($urandom_range(0, 64));
			value = 64'h8000_0000_0000_0000 + value - 64'd32;
		end else if (kind < 60) begin
			value = 64'd1 << $urandom_range(1, 63);
		end else if (kind < 70) begin
			value = WordW'($urandom_range(0, 1000));
			value = ~value;
		end else begin
			value = {$urandom, $urandom};
		end
		return value;
	endfunction

	task automatic send_word(input logic kind, input logic [WordW-1:0] bound,
		input logic [WordW-1:0] new_seed);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		limit <= bound;
		seed <= new_seed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_index.push_back(predict_index(kind, bound, new_seed));
		if (kind == ReqSeed)
			seeds_sent++;
		else
			draws_sent++;
	endtask

	task automatic send_random_word();
		logic [WordW-1:0] junk;
		logic [WordW-1:0] new_seed;
		junk = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) begin
			new_seed = ($urandom_range(0, 4) == 0) ? '0 : {$urandom, $urandom};
			send_word(ReqSeed, junk, new_seed);
		end else begin
			send_word(ReqDraw, pick_limit(), junk);
		end
	endtask

	// Receiver: after each word it takes, it may stall at random (not in the no-idling test); the
	// hold-off overrides everything.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_gap <= 0;
		end else if (hold_off) begin
			out_stall <= 1'b1;
		end else if (sink_gap != 0) begin
			out_stall <= 1'b1;
			sink_gap <= sink_gap - 1;
		end else if (out_valid && !out_stall && !no_idle) begin
			sink_draw = $urandom_range(0, 11);
			out_stall <= (sink_draw != 0);
			sink_gap <= (sink_draw != 0) ? sink_draw - 1 : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : output_hold
		forever begin
			wait (hold_request);
			@(posedge clk);
			hold_off <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			hold_off <= 1'b0;
			hold_request = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_index.size() == 0) begin
				report_mismatch("index with nothing outstanding", '0, index);
			end else begin
				index_due = expected_index.pop_front();
				results_checked++;
				if (index !== index_due)
					report_mismatch("index", index_due, index);
			end
		end
	end

	task automatic test_directed();
		// The first draw comes straight from the reset state.
		send_word(ReqDraw, 64'd1000, '0);
		send_word(ReqDraw, 64'd0, {$urandom, $urandom});
		send_word(ReqDraw, 64'd1, '0);
		send_word(ReqSeed, '1, '0);
		send_word(ReqDraw, 64'd2, '0);
		send_word(ReqDraw, 64'd3, '0);
		send_word(ReqDraw, '1, '0);
		send_word(ReqDraw, 64'h8000_0000_0000_0000, '0);
		repeat (3) send_word(ReqDraw, 64'h8000_0000_0000_0001, '0);
		send_word(ReqSeed, '0, '1);
		send_word(ReqDraw, 64'h0000_0001_0000_0000, '0);
		send_word(ReqDraw, {$urandom, $urandom}, {$urandom, $urandom});
		send_word(ReqSeed, {$urandom, $urandom}, {$urandom, $urandom});
		send_word(ReqDraw, {$urandom, $urandom}, '0);
		send_word(ReqSeed, '0, 64'd1);
		send_word(ReqDraw, 64'h8000_0000_0000_0003, '0);
		send_word(ReqDraw, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		send_word(ReqSeed, '0, GoldenGamma);
		send_word(ReqDraw, 64'd7, '0);
	endtask

	task automatic test_random_mix(input int unsigned count);
		repeat (count) send_random_word();
	endtask

	// The receiver stops taking words while the sender keeps offering, so the result
	// register and the sequencer both fill and the input must stall.
	task automatic test_back_pressure();
		hold_request = 1'b1;
		repeat (40) send_random_word();
	endtask

	task automatic test_no_idling();
		no_idle = 1'b1;
		repeat (80) send_random_word();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(300);
		test_back_pressure();
		test_no_idling();
		test_random_mix(200);
		in_valid <= 1'b0;
		while (expected_index.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d draws and %0d seed loads; the predictor saw %0d rejected outputs.",
			draws_sent, seeds_sent, redraws);
		$display("Checked %0d indices in %0d cycles, %0d mismatches.",
			results_checked, cycle_count, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
